### design/particle_pair_overlap_resolver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circle overlap resolver
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_PAIR_OVERLAP_RESOLVER_MACROS_SVH
`define PARTICLE_PAIR_OVERLAP_RESOLVER_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold in the same cycle as the trigger.
`define PPOR_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");
// The condition must hold in the cycle after the trigger.
`define PPOR_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");
`else
`define PPOR_ASSERT_SAME(label, clk, rst, trig, cond)
`define PPOR_ASSERT_NEXT(label, clk, rst, trig, cond)
`endif
`endif

### design/ppor_pkg.sv
// ----------------------------------------------------------------------------
// Circle overlap resolver package
// Shared widths, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ppor_pkg;

   localparam int POS_FRAC_BITS_DEF = 16;
   localparam int POS_W   = 20;
   localparam int RAD_W   = 16;
   localparam int CNT_W   = 16;
   localparam int DIFF_W  = POS_W + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int ROOT_W  = DIFF_W;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Transaction kinds.
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_RESOLVE = 1'b1;

   // Push factor 11/20 = 1.1 * 0.5; the divisor 20 is taken as 5 times 4.
   localparam int PUSH_NUM   = 11;
   localparam int PUSH_SHIFT = 2;
   localparam int PUSH_ODD   = 5;

   // Axis select.
   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   typedef struct packed {
      logic accept;
      logic sqr;
      logic sqrt_init;
      logic sqrt_step;
      logic div_start;
      logic scale;
      logic take_delta;
      logic mul;
      logic take_axis;
      logic axis;
      logic apply;
      logic out_load;
   } ppor_cmd_type;

   typedef struct packed {
      logic is_load;
      logic cmp_ok;
      logic sqrt_last;
      logic chk_ok;
      logic div_busy;
   } ppor_status_type;

endpackage

### design/ppor_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Bit-serial unsigned divider, one quotient bit per cycle. The upper part of
// the dividend must be below the divisor, so the quotient fits QUO_W bits.
// ----------------------------------------------------------------------------
module ppor_div #(
   parameter int QUO_W = ppor_pkg::POS_FRAC_BITS_DEF + 1,
   parameter int NUM_W = QUO_W + ppor_pkg::ROOT_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            dividend,
   input  logic [ppor_pkg::ROOT_W-1:0] divisor,
   output logic                        busy,
   output logic [QUO_W-1:0]            quotient
);
   import ppor_pkg::*;

   localparam int CW = $clog2(QUO_W + 1);

   logic [ROOT_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]  num_ff, num_in;
   logic [ROOT_W-1:0] den_ff, den_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [ROOT_W:0]   trial;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial  = {rem_ff, num_ff[QUO_W-1]};
      rem_in = rem_ff;
      num_in = num_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = dividend[NUM_W-1:QUO_W];
         num_in = dividend[QUO_W-1:0];
         den_in = divisor;
         cnt_in = CW'(QUO_W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = ROOT_W'(trial - {1'b0, den_ff});
            num_in = {num_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[ROOT_W-1:0];
            num_in = {num_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = num_ff;

endmodule

### design/ppor_dpath.sv
// ----------------------------------------------------------------------------
// Circle overlap resolver datapath
// Object state, offset and squares, iterative square root, shared divider
// and the saturating position update.
// ----------------------------------------------------------------------------
module ppor_dpath #(
   parameter int POS_FRAC_BITS = ppor_pkg::POS_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ppor_pkg::ppor_cmd_type             cmd,
   output ppor_pkg::ppor_status_type          status,
   input  logic                               in_opcode,
   input  logic signed [ppor_pkg::POS_W-1:0]  in_pos_x,
   input  logic signed [ppor_pkg::POS_W-1:0]  in_pos_y,
   input  logic [ppor_pkg::RAD_W-1:0]         in_radius,
   output logic signed [ppor_pkg::POS_W-1:0]  other_x,
   output logic signed [ppor_pkg::POS_W-1:0]  other_y,
   output logic signed [ppor_pkg::POS_W-1:0]  object_x,
   output logic signed [ppor_pkg::POS_W-1:0]  object_y,
   output logic                               overlapped,
   output logic [ppor_pkg::CNT_W-1:0]         compare_count
);
   import ppor_pkg::*;

   localparam int RSW   = POS_FRAC_BITS;
   localparam int QW    = RSW + 1;
   localparam int NW    = QW + ROOT_W;
   localparam int RSQ_W = 2 * QW;
   localparam int SW    = (QW + 2 > POS_W + 2) ? QW + 2 : POS_W + 2;
   localparam int SQCW  = $clog2(ROOT_W);
   localparam int MW    = QW + 4 - PUSH_SHIFT;
   localparam int DK    = MW + 2;
   localparam logic [63:0] EPS = (64'd1 << (2 * POS_FRAC_BITS)) / 64'd10000;
   localparam logic [63:0] RECIP_W =
      ((64'd1 << DK) + 64'(PUSH_ODD - 1)) / 64'(PUSH_ODD);
   localparam logic [MW-1:0] RECIP = RECIP_W[MW-1:0];
   localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (POS_W - 1)) - 1);
   localparam logic signed [SW-1:0] SAT_LO = -SW'(1 << (POS_W - 1));

   // Object state.
   logic signed [POS_W-1:0] held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic [RAD_W-1:0]        held_r_ff, held_r_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;

   // Per-item working registers.
   logic                    load_ff;
   logic signed [POS_W-1:0] px_ff, py_ff, oth_x_ff, oth_y_ff;
   logic [DIFF_W-1:0]       ax_ff, ay_ff;
   logic                    sx_ff, sy_ff, hit_ff;
   logic [QW-1:0]           rsum_ff, delta_ff, cx_ff, cy_ff;
   logic [SQ_W-1:0]         sqx_ff, sqy_ff;
   logic [RSQ_W-1:0]        rsq_ff;
   logic [NW-1:0]           prod_ff;
   logic [MW-1:0]           scale_ff;

   // Square root state.
   logic [SQ_W-1:0]     op_ff;
   logic [ROOT_W+1:0]   srem_ff, srem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SQCW-1:0]     sqc_ff;

   // Output register.
   logic signed [POS_W-1:0] o_ox_ff, o_oy_ff, o_bx_ff, o_by_ff;
   logic                    o_hit_ff;
   logic [CNT_W-1:0]        o_cnt_ff;

   logic [RSW-1:0]           hr_s, ir_s;
   logic signed [DIFF_W-1:0] dx, dy;
   logic [SQ_W:0]            dist2;
   logic [ROOT_W+3:0]        r2, strial;
   logic [QW-1:0]            gap;
   logic [QW+3:0]            gap_x;
   logic [2*MW-1:0]          dprod;
   logic                     div_busy;
   logic [QW-1:0]            div_q;
   logic signed [SW-1:0]     csx, csy, nbx, nby, nox, noy;

   // Radii brought to the position fraction width.
   generate
      if (POS_FRAC_BITS >= RAD_W) begin : g_rad_up
         assign hr_s = RSW'(held_r_ff) << (POS_FRAC_BITS - RAD_W);
         assign ir_s = RSW'(in_radius) << (POS_FRAC_BITS - RAD_W);
      end else begin : g_rad_dn
         assign hr_s = RSW'(held_r_ff >> (RAD_W - POS_FRAC_BITS));
         assign ir_s = RSW'(in_radius >> (RAD_W - POS_FRAC_BITS));
      end
   endgenerate

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SW-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[POS_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[POS_W-1:0];
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   // Offset from the other circle to the object.
   assign dx = DIFF_W'(held_x_ff) - DIFF_W'(in_pos_x);
   assign dy = DIFF_W'(held_y_ff) - DIFF_W'(in_pos_y);

   // Overlap test on the squared distance.
   assign dist2 = (SQ_W + 1)'(sqx_ff) + (SQ_W + 1)'(sqy_ff);

   // Square root step: two operand bits in, one root bit out.
   always_comb begin
      r2      = {srem_ff, op_ff[SQ_W-1:SQ_W-2]};
      strial  = (ROOT_W + 4)'({root_ff, 2'b01});
      srem_in = srem_ff;
      root_in = root_ff;
      if (r2 >= strial) begin
         srem_in = (ROOT_W + 2)'(r2 - strial);
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         srem_in = (ROOT_W + 2)'(r2);
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   // Push distance: overlap times 11, over 4 by a shift, then over 5 by a
   // reciprocal multiplication that is exact over the whole operand range.
   assign gap   = QW'(rsum_ff - QW'(root_ff));
   assign gap_x = (QW + 4)'(gap) * (QW + 4)'(PUSH_NUM);
   assign dprod = (2 * MW)'(scale_ff) * (2 * MW)'(RECIP);

   // Divider for the offset times delta over the root.
   ppor_div #(.QUO_W(QW), .NUM_W(NW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (root_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // Signed corrections and saturated new positions.
   assign csx = sx_ff ? -$signed(SW'(cx_ff)) : $signed(SW'(cx_ff));
   assign csy = sy_ff ? -$signed(SW'(cy_ff)) : $signed(SW'(cy_ff));
   assign nbx = SW'(held_x_ff) + csx;
   assign nby = SW'(held_y_ff) + csy;
   assign nox = SW'(px_ff) - csx;
   assign noy = SW'(py_ff) - csy;

   // Object state update.
   always_comb begin
      held_x_in = held_x_ff;
      held_y_in = held_y_ff;
      held_r_in = held_r_ff;
      cnt_in    = cnt_ff;
      if (cmd.accept) begin
         if (in_opcode == OP_LOAD) begin
            held_x_in = in_pos_x;
            held_y_in = in_pos_y;
            held_r_in = in_radius;
            cnt_in    = '0;
         end else if (cnt_ff != CNT_MAX) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (cmd.apply) begin
         held_x_in = sat_pos(nbx);
         held_y_in = sat_pos(nby);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff <= '0;
         held_y_ff <= '0;
         held_r_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         held_x_ff <= held_x_in;
         held_y_ff <= held_y_in;
         held_r_ff <= held_r_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Working registers, loaded under controller commands.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         load_ff  <= (in_opcode == OP_LOAD);
         px_ff    <= in_pos_x;
         py_ff    <= in_pos_y;
         oth_x_ff <= (in_opcode == OP_RESOLVE) ? in_pos_x : '0;
         oth_y_ff <= (in_opcode == OP_RESOLVE) ? in_pos_y : '0;
         hit_ff   <= 1'b0;
         sx_ff    <= dx[DIFF_W-1];
         sy_ff    <= dy[DIFF_W-1];
         ax_ff    <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
         ay_ff    <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
         rsum_ff  <= QW'(hr_s) + QW'(ir_s);
      end
      if (cmd.sqr) begin
         sqx_ff <= ax_ff * ax_ff;
         sqy_ff <= ay_ff * ay_ff;
         rsq_ff <= rsum_ff * rsum_ff;
      end
      if (cmd.sqrt_init) begin
         op_ff   <= SQ_W'(dist2);
         srem_ff <= '0;
         root_ff <= '0;
         sqc_ff  <= SQCW'(ROOT_W - 1);
      end else if (cmd.sqrt_step) begin
         op_ff   <= op_ff << 2;
         srem_ff <= srem_in;
         root_ff <= root_in;
         sqc_ff  <= sqc_ff - 1'b1;
      end
      if (cmd.scale) begin
         scale_ff <= MW'(gap_x >> PUSH_SHIFT);
      end
      if (cmd.take_delta) begin
         delta_ff <= dprod[DK +: QW];
      end
      if (cmd.mul) begin
         prod_ff <= NW'(((cmd.axis == AXIS_X) ? ax_ff : ay_ff) * delta_ff);
      end
      if (cmd.take_axis) begin
         if (cmd.axis == AXIS_X) begin
            cx_ff <= div_q;
         end else begin
            cy_ff <= div_q;
         end
      end
      if (cmd.apply) begin
         oth_x_ff <= sat_pos(nox);
         oth_y_ff <= sat_pos(noy);
         hit_ff   <= 1'b1;
      end
      if (cmd.out_load) begin
         o_ox_ff  <= oth_x_ff;
         o_oy_ff  <= oth_y_ff;
         o_bx_ff  <= held_x_ff;
         o_by_ff  <= held_y_ff;
         o_hit_ff <= hit_ff;
         o_cnt_ff <= cnt_ff;
      end
   end

   // Status back to the controller.
   assign status.is_load   = load_ff;
   assign status.cmp_ok    = (64'(dist2) < 64'(rsq_ff)) && (64'(dist2) > EPS);
   assign status.sqrt_last = (sqc_ff == '0);
   assign status.chk_ok    = (root_ff != '0) && (32'(rsum_ff) > 32'(root_ff));
   assign status.div_busy  = div_busy;

   assign other_x       = o_ox_ff;
   assign other_y       = o_oy_ff;
   assign object_x      = o_bx_ff;
   assign object_y      = o_by_ff;
   assign overlapped    = o_hit_ff;
   assign compare_count = o_cnt_ff;

endmodule

### design/ppor_ctrl.sv
// ----------------------------------------------------------------------------
// Circle overlap resolver controller
// Sequences one transaction through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
`include "particle_pair_overlap_resolver_macros.svh"

module ppor_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  ppor_pkg::ppor_status_type status,
   output ppor_pkg::ppor_cmd_type    cmd
);
   import ppor_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SQR    = 4'd1;
   localparam logic [3:0] S_CMP    = 4'd2;
   localparam logic [3:0] S_SQRT   = 4'd3;
   localparam logic [3:0] S_CHK    = 4'd4;
   localparam logic [3:0] S_DLT    = 4'd5;
   localparam logic [3:0] S_MUL    = 4'd6;
   localparam logic [3:0] S_STD    = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_APPLY  = 4'd9;
   localparam logic [3:0] S_FINISH = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       axis_ff, axis_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free = !valid_ff || rsp_tready;

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      cmd        = '0;
      cmd.axis   = axis_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_SQR;
            end
         end
         S_SQR: begin
            if (status.is_load) begin
               state_in = S_FINISH;
            end else begin
               cmd.sqr  = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (status.cmp_ok) begin
               cmd.sqrt_init = 1'b1;
               state_in      = S_SQRT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (status.sqrt_last) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (status.chk_ok) begin
               cmd.scale = 1'b1;
               state_in  = S_DLT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DLT: begin
            cmd.take_delta = 1'b1;
            axis_in        = AXIS_X;
            state_in       = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_STD;
         end
         S_STD: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!status.div_busy) begin
               cmd.take_axis = 1'b1;
               if (axis_ff == AXIS_X) begin
                  axis_in  = AXIS_Y;
                  state_in = S_MUL;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register valid flag.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= AXIS_X;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

   // The divider must report busy right after each start.
   `PPOR_ASSERT_NEXT(a_div_started, clock, reset, cmd.div_start, status.div_busy)
   // The divider stays idle while the square root runs.
   `PPOR_ASSERT_SAME(a_div_idle_sqrt, clock, reset, state_ff == S_SQRT, !status.div_busy)
   // A loaded result is presented on the next cycle.
   `PPOR_ASSERT_NEXT(a_out_valid, clock, reset, cmd.out_load, rsp_tvalid)
   // A load transaction never enters the square root.
   `PPOR_ASSERT_SAME(a_load_short, clock, reset, state_ff == S_SQRT, !status.is_load)

endmodule

### design/particle_pair_overlap_resolver.sv
// ----------------------------------------------------------------------------
// Circle overlap resolver, top level
// Pushes an object circle and a stream of other circles apart on overlap.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  req_*     in         load or resolve transaction: kind, position, radius
//  rsp_*     out        corrected other circle, object, hit flag, count
//
// A load transaction passes from acceptance through S_SQR to S_FINISH; a
// resolve transaction that fails the squared test leaves for S_FINISH from
// S_CMP, and one that fails the root check leaves from S_CHK after the root.
// The run time of an overlapping resolve transaction is set by the 21-step
// square root and two passes of the bit-serial divider, one per axis.
// One transaction is in work at a time; the next one is accepted in the cycle
// after the result is loaded. A result left waiting holds the controller in
// its last state. Reset is synchronous and clears the object.
//
module particle_pair_overlap_resolver #(
   parameter int POS_FRAC_BITS = ppor_pkg::POS_FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [19:0] pos_x, [39:20] pos_y, [55:40] radius
   input  logic [55:0]  req_tdata,
   // [0] opcode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [19:0] other_x, [39:20] other_y, [59:40] object_x, [79:60] object_y,
   // [95:80] compare_count
   output logic [95:0]  rsp_tdata,
   // [0] overlapped
   output logic         rsp_tuser
);
   import ppor_pkg::*;

   ppor_cmd_type    cmd;
   ppor_status_type status;

   logic signed [POS_W-1:0] other_x, other_y, object_x, object_y;
   logic                    overlapped;
   logic [CNT_W-1:0]        compare_count;

   ppor_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ppor_dpath #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .in_opcode     (req_tuser),
      .in_pos_x      (req_tdata[19:0]),
      .in_pos_y      (req_tdata[39:20]),
      .in_radius     (req_tdata[55:40]),
      .other_x       (other_x),
      .other_y       (other_y),
      .object_x      (object_x),
      .object_y      (object_y),
      .overlapped    (overlapped),
      .compare_count (compare_count)
   );

   // Result packing.
   assign rsp_tdata = {compare_count, object_y, object_x, other_y, other_x};
   assign rsp_tuser = overlapped;

endmodule

### tb/particle_pair_overlap_resolver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circle overlap resolver testbench
// Sends load and resolve transactions with random gaps, and stalls the result
// channel on a pattern of its own. A behavioral predictor of the object
// circle works out each result, and a checker compares them field by field.
// ----------------------------------------------------------------------------
module particle_pair_overlap_resolver_tb;
   import ppor_pkg::*;

   localparam int   FRAC       = POS_FRAC_BITS_DEF;
   localparam int   CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [19:0] other_x;
      logic [19:0] other_y;
      logic [19:0] object_x;
      logic [19:0] object_y;
      logic        overlapped;
      logic [15:0] compare_count;
   } circle_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;

   // Predictor state for the object circle.
   longint      obj_x, obj_y;
   longint      obj_radius;
   longint      compares;

   circle_result_type expected_results[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          stall_phase = 0;

   particle_pair_overlap_resolver uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint clamp_pos(longint v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
   endfunction

   function automatic longint root_floor(longint v);
      longint r;
      r = longint'($floor($sqrt(real'(v))));
      while (r * r > v) r--;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function automatic longint axis_push(longint d, longint delta, longint root_len);
      longint q;
      q = ((d < 0) ? -d : d) * delta / root_len;
      return (d < 0) ? -q : q;
   endfunction

   // Advances the predictor by one transaction and returns the result.
   function automatic circle_result_type resolve_circle(logic op, logic [19:0] px_in,
                                                       logic [19:0] py_in,
                                                       logic [15:0] rad);
      circle_result_type res;
      longint px, py, dx, dy, dist2, rsum, eps, root_len, delta, cx, cy, ox, oy;
      px = longint'($signed(px_in));
      py = longint'($signed(py_in));
      ox = 0;
      oy = 0;
      res.overlapped = 1'b0;
      if (op == OP_LOAD) begin
         obj_x = px;
         obj_y = py;
         obj_radius = rad;
         compares = 0;
      end else begin
         dx = obj_x - px;
         dy = obj_y - py;
         dist2 = dx * dx + dy * dy;
         rsum = (obj_radius << (FRAC - 16)) + (longint'(rad) << (FRAC - 16));
         eps = (64'd1 << (2 * FRAC)) / 10000;
         if (compares < 65535) compares++;
         ox = px;
         oy = py;
         if (dist2 < rsum * rsum && dist2 > eps) begin
            root_len = root_floor(dist2);
            if (root_len != 0 && rsum > root_len) begin
               delta = (rsum - root_len) * 11 / 20;
               cx = axis_push(dx, delta, root_len);
               cy = axis_push(dy, delta, root_len);
               obj_x = clamp_pos(obj_x + cx);
               obj_y = clamp_pos(obj_y + cy);
               ox = clamp_pos(px - cx);
               oy = clamp_pos(py - cy);
               res.overlapped = 1'b1;
            end
         end
      end
      res.other_x = ox[19:0];
      res.other_y = oy[19:0];
      res.object_x = obj_x[19:0];
      res.object_y = obj_y[19:0];
      res.compare_count = compares[15:0];
      return res;
   endfunction

   // Sends one transaction in bursts with random gaps between them.
   task automatic send_circle(logic op, logic [19:0] px, logic [19:0] py,
                              logic [15:0] rad);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {rad, py, px};
      expected_results.push_back(resolve_circle(op, px, py, rad));
      do @(posedge clock); while (!req_tready);
   endtask

   // Holds the sender idle until every expected result has come.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // A random other circle placed near the object so that overlaps are common.
   task automatic send_near(int spread);
      longint px, py;
      px = clamp_pos(obj_x + $signed($urandom_range(0, 2 * spread)) - spread);
      py = clamp_pos(obj_y + $signed($urandom_range(0, 2 * spread)) - spread);
      send_circle(OP_RESOLVE, px[19:0], py[19:0], 16'($urandom));
   endtask

   task automatic test_directed();
      send_circle(OP_RESOLVE, 20'd1000, 20'd0, 16'hFFFF);      // before any load
      send_circle(OP_LOAD, 20'd0, 20'd0, 16'hFFFF);
      send_circle(OP_RESOLVE, 20'd0, 20'd0, 16'hFFFF);         // coincident
      send_circle(OP_RESOLVE, 20'd3, 20'd2, 16'hFFFF);         // under epsilon
      send_circle(OP_RESOLVE, 20'd40000, 20'hFFFFF, 16'hFFFF);
      send_circle(OP_RESOLVE, 20'h80000, 20'h7FFFF, 16'h0000); // far apart
      send_circle(OP_LOAD, 20'h7FFFF, 20'h7FFFF, 16'hFFFF);
      send_circle(OP_RESOLVE, 20'h7F000, 20'h7F800, 16'hFFFF); // clamp object
      send_circle(OP_LOAD, 20'h80000, 20'h80000, 16'hFFFF);
      send_circle(OP_RESOLVE, 20'h81000, 20'h80800, 16'hFFFF);
      send_circle(OP_LOAD, 20'd0, 20'd0, 16'h8000);
      send_circle(OP_RESOLVE, 20'd30000, 20'd0, 16'h0000);     // overlap on x
      send_circle(OP_RESOLVE, 20'd0, 20'hF0000, 16'h8000);
      send_circle(OP_LOAD, 20'h7F000, 20'd0, 16'hFFFF);
      send_circle(OP_RESOLVE, 20'h80000, 20'd0, 16'hFFFF);     // far apart
      send_circle(OP_LOAD, 20'h55555, 20'hAAAAA, 16'h5555);
      send_circle(OP_RESOLVE, 20'hAAAAA, 20'h55555, 16'hAAAA);
   endtask

   // Sends a load and one resolve transaction only after all results drain, then drains again.
   task automatic test_drain_pause();
      wait_drained();
      send_circle(OP_LOAD, 20'd100, 20'd200, 16'h4000);
      send_near(60000);
      wait_drained();
   endtask

   // Runs the compare count up with cheap back-to-back misses.
   task automatic test_count_run();
      send_circle(OP_LOAD, 20'd0, 20'd0, 16'd0);
      repeat (300) begin
         req_tvalid <= 1'b1;
         req_tuser <= OP_RESOLVE;
         req_tdata <= {16'd0, 20'h40000, 20'h40000};
         expected_results.push_back(resolve_circle(OP_RESOLVE, 20'h40000,
                                                   20'h40000, 16'd0));
         do @(posedge clock); while (!req_tready);
      end
      wait_drained();
   endtask

   task automatic test_random();
      int roll;
      repeat (1080) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)
            send_circle(OP_LOAD, 20'($urandom), 20'($urandom), 16'($urandom));
         else if (roll < 75)
            send_near((roll < 40) ? 40000 : 160000);
         else
            send_circle(OP_RESOLVE, 20'($urandom), 20'($urandom), 16'($urandom));
      end
   endtask

   // Result stall pattern: runs of ready and stall, sometimes none.
   always @(posedge clock) begin
      if (stall_phase == 0) stall_phase <= $urandom_range(1, 40);
      else stall_phase <= stall_phase - 1;
      rsp_tready <= (stall_phase > 25) ? 1'b1 : (stall_phase % 5 != 0);
   end

   // Checks each result transaction against the oldest expectation.
   always @(posedge clock) begin
      circle_result_type exp_r, got;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[19:0], rsp_tdata[39:20], rsp_tdata[59:40],
                rsp_tdata[79:60], rsp_tuser, rsp_tdata[95:80]};
         if (expected_results.size() == 0) begin
            $error("unexpected result transaction");
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            if (got.other_x !== exp_r.other_x) begin
               $error("other_x expected %h got %h", exp_r.other_x, got.other_x);
               error_count++;
            end
            if (got.other_y !== exp_r.other_y) begin
               $error("other_y expected %h got %h", exp_r.other_y, got.other_y);
               error_count++;
            end
            if (got.object_x !== exp_r.object_x) begin
               $error("object_x expected %h got %h", exp_r.object_x, got.object_x);
               error_count++;
            end
            if (got.object_y !== exp_r.object_y) begin
               $error("object_y expected %h got %h", exp_r.object_y, got.object_y);
               error_count++;
            end
            if (got.overlapped !== exp_r.overlapped) begin
               $error("overlapped expected %b got %b", exp_r.overlapped,
                      got.overlapped);
               error_count++;
            end
            if (got.compare_count !== exp_r.compare_count) begin
               $error("compare_count expected %0d got %0d", exp_r.compare_count,
                      got.compare_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      obj_x = 0;
      obj_y = 0;
      obj_radius = 0;
      compares = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_drain_pause();
      test_count_run();
      test_random();
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
